### rtl/cle_pkg.sv
package cle_pkg;

    // Character codes
    localparam logic [7:0] CH_BELL   = 8'h07;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_CTRL_U = 8'h15;
    localparam logic [7:0] CH_SP     = 8'h20;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_AT     = 8'h40;
    localparam logic [7:0] CH_DEL    = 8'h7F;
    localparam logic [7:0] CH_NUL    = 8'h00;

    // Limit register
    localparam int          LIMIT_W     = 6;
    localparam logic [5:0]  LIMIT_RESET = 6'd32;

    // Command queue depth between front and back
    localparam int QDEPTH = 2;

    typedef enum logic [1:0] {
        CMD_PRINT = 2'd0,
        CMD_ERASE = 2'd1,
        CMD_KILL  = 2'd2,
        CMD_END   = 2'd3
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic [6:0]  ch;
    } cmd_t;

endpackage

### rtl/cle_front.sv
module cle_front
    import cle_pkg::*;
(
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,      // [7:0] in_byte
    input  logic        q_full,
    output logic        q_push,
    output cmd_t        q_cmd
);

    logic keep;

    // Classify the incoming byte; ignored bytes are consumed without a command
    always_comb
    begin
        keep       = 1'b1;
        q_cmd.ch   = s_tdata[6:0];
        q_cmd.kind = CMD_PRINT;
        if (s_tdata == CH_LF || s_tdata == CH_CR)
        begin
            q_cmd.kind = CMD_END;
        end
        else if (s_tdata == CH_BS || s_tdata == CH_HASH || s_tdata == CH_DEL)
        begin
            q_cmd.kind = CMD_ERASE;
        end
        else if (s_tdata == CH_AT || s_tdata == CH_CTRL_U)
        begin
            q_cmd.kind = CMD_KILL;
        end
        else if (s_tdata >= CH_SP && s_tdata < CH_DEL)
        begin
            q_cmd.kind = CMD_PRINT;
        end
        else
        begin
            keep = 1'b0;
        end
    end

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full && keep;

endmodule

### rtl/cle_queue.sv
module cle_queue
    import cle_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  cmd_t  push_cmd,
    input  logic  pop,
    output cmd_t  head_cmd,
    output logic  empty,
    output logic  full
);

    localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CNT_W = $clog2(QDEPTH + 1);

    cmd_t              slot_reg [QDEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    assign empty    = (count_reg == '0);
    assign full     = (count_reg == CNT_W'(QDEPTH));
    assign head_cmd = slot_reg[rd_ptr_reg];

    // Pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Payload slots
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

### rtl/cle_back.sv
module cle_back
    import cle_pkg::*;
#(
    parameter int LINE_BYTES = 32
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [LIMIT_W-1:0]  cfg_wr_data,
    input  logic                q_empty,
    input  cmd_t                q_cmd,
    output logic                q_pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [7:0]          m_tdata,
    output logic                m_tuser,
    output logic                m_tlast
);

    localparam int ADDR_W = $clog2(LINE_BYTES);

    typedef enum logic [6:0] {
        ST_IDLE     = 7'b0000001,
        ST_ERASE_SP = 7'b0000010,
        ST_ERASE_BS = 7'b0000100,
        ST_KILL_CR  = 7'b0001000,
        ST_LINE_RD  = 7'b0010000,
        ST_LINE_OUT = 7'b0100000,
        ST_LINE_END = 7'b1000000
    } state_t;

    state_t              state_reg, state_next;
    logic [LIMIT_W-1:0]  limit_reg;
    logic [ADDR_W-1:0]   len_reg, len_next;
    logic [ADDR_W-1:0]   idx_reg, idx_next;

    logic                out_valid_reg, out_valid_next;
    logic [7:0]          out_byte_reg, out_byte_next;
    logic                out_dest_reg, out_dest_next;
    logic                out_last_reg, out_last_next;

    logic [6:0]          store_mem [LINE_BYTES];
    logic [6:0]          rd_data_reg;
    logic                mem_we;

    logic                slot_free;
    logic [6:0]          lim_eff;
    logic [6:0]          capacity;
    logic                has_room;

    // Capacity: min(limit, LINE_BYTES) - 1, zero for a limit of 0 or 1
    always_comb
    begin
        lim_eff  = ({1'b0, limit_reg} > 7'(LINE_BYTES)) ? 7'(LINE_BYTES) : {1'b0, limit_reg};
        capacity = (lim_eff == '0) ? '0 : lim_eff - 1'b1;
        has_room = (7'(len_reg) < capacity);
    end

    assign slot_free = !out_valid_reg || m_tready;

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        len_next       = len_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_byte_next  = out_byte_reg;
        out_dest_next  = out_dest_reg;
        out_last_next  = out_last_reg;
        q_pop          = 1'b0;
        mem_we         = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty && slot_free)
                begin
                    q_pop = 1'b1;
                    case (q_cmd.kind)
                        CMD_PRINT:
                        begin
                            out_valid_next = 1'b1;
                            out_dest_next  = 1'b0;
                            out_last_next  = 1'b1;
                            if (has_room)
                            begin
                                mem_we        = 1'b1;
                                len_next      = len_reg + 1'b1;
                                out_byte_next = {1'b0, q_cmd.ch};
                            end
                            else
                            begin
                                out_byte_next = CH_BELL;
                            end
                        end
                        CMD_ERASE:
                        begin
                            if (len_reg != '0)
                            begin
                                len_next       = len_reg - 1'b1;
                                out_valid_next = 1'b1;
                                out_byte_next  = CH_BS;
                                out_dest_next  = 1'b0;
                                out_last_next  = 1'b0;
                                state_next     = ST_ERASE_SP;
                            end
                        end
                        CMD_KILL:
                        begin
                            len_next       = '0;
                            out_valid_next = 1'b1;
                            out_byte_next  = CH_LF;
                            out_dest_next  = 1'b0;
                            out_last_next  = 1'b0;
                            state_next     = ST_KILL_CR;
                        end
                        CMD_END:
                        begin
                            idx_next       = '0;
                            out_valid_next = 1'b1;
                            out_byte_next  = CH_LF;
                            out_dest_next  = 1'b0;
                            out_last_next  = 1'b0;
                            state_next     = ST_LINE_RD;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_ERASE_SP:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = CH_SP;
                    out_dest_next  = 1'b0;
                    out_last_next  = 1'b0;
                    state_next     = ST_ERASE_BS;
                end
            end
            ST_ERASE_BS:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = CH_BS;
                    out_dest_next  = 1'b0;
                    out_last_next  = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_KILL_CR:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = CH_CR;
                    out_dest_next  = 1'b0;
                    out_last_next  = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_LINE_RD:
            begin
                // store read of idx is launched this cycle
                state_next = (idx_reg < len_reg) ? ST_LINE_OUT : ST_LINE_END;
            end
            ST_LINE_OUT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = {1'b0, rd_data_reg};
                    out_dest_next  = 1'b1;
                    out_last_next  = 1'b0;
                    idx_next       = idx_reg + 1'b1;
                    state_next     = ST_LINE_RD;
                end
            end
            ST_LINE_END:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = CH_NUL;
                    out_dest_next  = 1'b1;
                    out_last_next  = 1'b1;
                    len_next       = '0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            len_reg       <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
            limit_reg     <= LIMIT_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                limit_reg <= cfg_wr_data;
            end
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
        out_dest_reg <= out_dest_next;
        out_last_reg <= out_last_next;
    end

    // Line store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store_mem[len_reg] <= q_cmd.ch;
        end
        rd_data_reg <= store_mem[idx_reg];
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tuser  = out_dest_reg;
    assign m_tlast  = out_last_reg;

endmodule

### rtl/console_line_editor.sv
// Channel   Dir  Signals                         Contents
// s_        in   s_tvalid/s_tready/s_tdata       keyboard byte
// m_        out  m_tvalid/m_tready/m_tdata/      echo or line byte, dest, last
//                m_tuser/m_tlast
// cfg_      in   cfg_wr_en/cfg_wr_data           line limit
//
// Printable, erase and kill bytes: dequeue, then one beat per cycle while m_ is not
// stalled (1, 3 or 2 beats; an erase on an empty line gives none). Enter: newline beat,
// then for each kept character a registered store read and an output beat, then the
// terminator beat. The store read is registered in the sequencer (ST_LINE_RD).
// Reset clears the line length, the queue and the output register; limit resets to 32.
// A stall on m_ stops the sequencer; s_ keeps taking beats until the queue is full.
module console_line_editor
    import cle_pkg::*;
#(
    parameter int LINE_BYTES = 32
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [LIMIT_W-1:0]  cfg_wr_data,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,     // [7:0] in_byte
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [7:0]          m_tdata,     // [7:0] out_byte
    output logic                m_tuser,     // [0] out_dest
    output logic                m_tlast
);

    logic q_push;
    logic q_pop;
    logic q_full;
    logic q_empty;
    cmd_t push_cmd;
    cmd_t head_cmd;

    cle_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (push_cmd)
    );

    cle_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (push_cmd),
        .pop      (q_pop),
        .head_cmd (head_cmd),
        .empty    (q_empty),
        .full     (q_full)
    );

    cle_back #(
        .LINE_BYTES (LINE_BYTES)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .q_empty     (q_empty),
        .q_cmd       (head_cmd),
        .q_pop       (q_pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

endmodule
